### design/hub75bs_pkg.sv
`default_nettype none

package hub75bs_pkg;

    localparam int PANEL_W_DEF       = 32;
    localparam int PANEL_H_DEF       = 32;
    localparam int PANELS_ACROSS_DEF = 2;
    localparam int PANELS_DOWN_DEF   = 1;
    localparam int PLANES_DEF        = 3;
    localparam int SLICE_TICKS_DEF   = 20;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int PLANE_W    = 2;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_SWAP  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_OE_MAX     = 1'b1;

    localparam logic [6:0] BRIGHT_MAX   = 7'd100;
    localparam logic [6:0] BRIGHT_RESET = 7'd100;
    localparam logic [7:0] OE_MAX_RESET = 8'd63;

    // Division by 100 of a product below 25600 as a multiply and shift.
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam int          PROD_W       = 15;

    localparam logic [7:0] GAMMA_STEPS [0:6] =
        '{8'd48, 8'd80, 8'd104, 8'd120, 8'd132, 8'd140, 8'd148};

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] pixel_x;
        logic [6:0] pixel_y;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } cmd_t;

    typedef struct packed {
        logic       upper_red;
        logic       upper_green;
        logic       upper_blue;
        logic       lower_red;
        logic       lower_green;
        logic       lower_blue;
        logic [2:0] row_address;
        logic       shift_clock;
        logic       latch_pulse;
        logic [7:0] oe_duty;
    } pins_t;

    function automatic logic [2:0] gamma3(input logic [7:0] level);
        logic [2:0] q;
        q = '0;
        for (int i = 0; i < 7; i++)
        begin
            if (level >= GAMMA_STEPS[i])
            begin
                q = q + 3'd1;
            end
        end
        return q;
    endfunction

endpackage

`default_nettype wire

### design/hub75_bitplane_scan_driver_core.sv
// HUB75 bit-plane scan driver with a double-buffered frame store.
// Commands arrive as beats on the cmd channel (valid/ready): a pixel write into the
// back buffer, a buffer swap, or a refresh tick. Each tick yields exactly one beat
// on the pins channel carrying the panel pin levels for that scan step; writes and
// swaps yield none. Brightness and maximum OE duty sit behind the APB port.
// A pins beat leaves after its tick passes the frame-store read register and then
// the output register. One command is taken per cycle while cmd_ready is high; the
// frame store has one write port and two read ports, so a shift step fetches its
// upper and lower pixel in a single access.
// After reset the block sweeps the whole frame store to zero, one entry per cycle;
// it holds 2^(1 + clog2(PANEL_H) + clog2(PANEL_W * panels)) entries (4096 with the
// default geometry). cmd_ready stays low during that sweep while APB writes are
// still taken. When the pins receiver stalls, up to two results are held and
// cmd_ready drops until the output register drains.
`default_nettype none

module hub75_bitplane_scan_driver_core #(
    parameter int PANEL_W       = hub75bs_pkg::PANEL_W_DEF,
    parameter int PANEL_H       = hub75bs_pkg::PANEL_H_DEF,
    parameter int PANELS_ACROSS = hub75bs_pkg::PANELS_ACROSS_DEF,
    parameter int PANELS_DOWN   = hub75bs_pkg::PANELS_DOWN_DEF,
    parameter int PLANES        = hub75bs_pkg::PLANES_DEF,
    parameter int SLICE_TICKS   = hub75bs_pkg::SLICE_TICKS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hub75bs_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [hub75bs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [hub75bs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                     pready,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_ready,
    input  wire hub75bs_pkg::cmd_t                   cmd,
    output logic                                     pins_valid,
    input  wire logic                                pins_ready,
    output hub75bs_pkg::pins_t                       pins
);

    localparam int CHAIN        = PANELS_ACROSS * PANELS_DOWN;
    localparam int PHYS_W       = PANEL_W * CHAIN;
    localparam int VIRT_W       = PANEL_W * PANELS_ACROSS;
    localparam int VIRT_H       = PANEL_H * PANELS_DOWN;
    localparam int ADDR_ROWS    = PANEL_H / 4;
    localparam int SHIFT_PANELS = 2 * CHAIN;
    localparam int XW           = $clog2(PHYS_W);
    localparam int YW           = $clog2(PANEL_H);
    localparam int AW           = 1 + YW + XW;
    localparam int DEPTH        = 1 << AW;
    localparam int COL_W        = $clog2(PANEL_W);
    localparam int PIDX_W       = $clog2(SHIFT_PANELS);
    localparam int RW           = $clog2(ADDR_ROWS);
    localparam int WORD_W       = 3 * PLANES;
    localparam int SLICE_W      = $clog2((SLICE_TICKS << (PLANES - 1)) + 1);
    localparam int PL_W         = hub75bs_pkg::PLANE_W;
    localparam int PROD_W       = hub75bs_pkg::PROD_W;
    localparam int MUL_W        = PROD_W + 13;

    typedef enum logic [1:0] {
        ST_BLANK,
        ST_SHIFT,
        ST_LATCH,
        ST_SHOW
    } scan_state_t;

    scan_state_t         state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [PIDX_W-1:0]   pidx_reg, pidx_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [PL_W-1:0]     plane_reg, plane_next;
    logic [SLICE_W-1:0]  slice_reg, slice_next;
    logic                front_reg, front_next;
    logic [6:0]          bright_reg, bright_next;
    logic [7:0]          oe_max_reg, oe_max_next;
    logic                clear_reg, clear_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                out_valid_reg, out_valid_next;

    logic                s1_shift_reg;
    logic                s1_latch_reg;
    logic                s1_show_reg;
    logic [2:0]          s1_row_reg;
    logic [PL_W-1:0]     s1_plane_reg;
    logic [PROD_W-1:0]   product_reg;
    hub75bs_pkg::pins_t  out_reg;

    logic [WORD_W-1:0]   frame_mem [DEPTH];
    logic [WORD_W-1:0]   rd_upper_reg;
    logic [WORD_W-1:0]   rd_lower_reg;

    logic                cmd_fire;
    logic                is_tick;
    logic                s1_adv;
    logic                cfg_we;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic                rd_en;
    logic [AW-1:0]       rd_addr_upper;
    logic [AW-1:0]       rd_addr_lower;

    logic [1:0]          x_q, y_q;
    logic [6:0]          x_r, y_r;
    logic                in_grid;
    logic [XW-1:0]       wr_px;
    logic [YW-1:0]       wr_py;
    logic [2:0]          r_g, g_g, b_g;
    logic [WORD_W-1:0]   wr_word;

    logic [XW-1:0]       fx;
    logic [YW-1:0]       y1, y2;
    logic [SLICE_W-1:0]  slice_inc;
    logic [SLICE_W-1:0]  slice_limit;
    logic [MUL_W-1:0]    duty_full;
    logic [2:0]          upper_bits, lower_bits;

    // The host port and the command handshake come first.
    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite;
    assign s1_adv    = !out_valid_reg || pins_ready;
    assign cmd_ready = !clear_reg && (!s1_valid_reg || s1_adv);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign is_tick   = cmd.action == hub75bs_pkg::ACT_TICK;

    always_comb
    begin
        unique case (paddr[2])
            hub75bs_pkg::REG_BRIGHTNESS: prdata = {25'd0, bright_reg};
            hub75bs_pkg::REG_OE_MAX:     prdata = {24'd0, oe_max_reg};
            default:                     prdata = '0;
        endcase
    end

    // A pixel write gets its chain address and its color word here.
    always_comb
    begin
        x_q = '0;
        y_q = '0;
        for (int k = 1; k < 4; k++)
        begin
            if (k < PANELS_ACROSS && {1'b0, cmd.pixel_x} >= 8'(k * PANEL_W))
            begin
                x_q = x_q + 2'd1;
            end
            if (k < PANELS_DOWN && {1'b0, cmd.pixel_y} >= 8'(k * PANEL_H))
            begin
                y_q = y_q + 2'd1;
            end
        end
    end

    assign x_r     = cmd.pixel_x - 7'(int'(x_q) * PANEL_W);
    assign y_r     = cmd.pixel_y - 7'(int'(y_q) * PANEL_H);
    assign in_grid = ({2'b0, cmd.pixel_x} < 9'(VIRT_W)) && ({2'b0, cmd.pixel_y} < 9'(VIRT_H));
    assign wr_px   = XW'((int'(y_q) * PANELS_ACROSS + int'(x_q)) * PANEL_W + int'(x_r));
    assign wr_py   = YW'(y_r);
    assign r_g     = hub75bs_pkg::gamma3(cmd.red_level);
    assign g_g     = hub75bs_pkg::gamma3(cmd.green_level);
    assign b_g     = hub75bs_pkg::gamma3(cmd.blue_level);

    always_comb
    begin
        wr_word = '0;
        for (int p = 0; p < PLANES; p++)
        begin
            wr_word[3*p +: 3] = {b_g[p], g_g[p], r_g[p]};
        end
    end

    assign mem_we = clear_reg
                    || (cmd_fire && cmd.action == hub75bs_pkg::ACT_WRITE && in_grid);
    assign mem_waddr = clear_reg ? clr_addr_reg : {~front_reg, wr_py, wr_px};
    assign mem_wdata = clear_reg ? '0 : wr_word;

    // A shift step reads the upper and lower pixel of its column.
    assign fx = XW'(int'(pidx_reg >> 1) * PANEL_W + int'(col_reg));
    assign y1 = pidx_reg[0] ? YW'(row_reg) : YW'(int'(row_reg) + ADDR_ROWS);
    assign y2 = YW'(int'(y1) + 2 * ADDR_ROWS);
    assign rd_en         = cmd_fire && is_tick && state_reg == ST_SHIFT;
    assign rd_addr_upper = {front_reg, y1, fx};
    assign rd_addr_lower = {front_reg, y2, fx};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_upper_reg <= frame_mem[rd_addr_upper];
            rd_lower_reg <= frame_mem[rd_addr_lower];
        end
    end

    // The scan sequence and the configuration registers advance here.
    assign slice_inc   = slice_reg + SLICE_W'(1);
    assign slice_limit = SLICE_W'(SLICE_TICKS) << plane_reg;

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        pidx_next      = pidx_reg;
        row_next       = row_reg;
        plane_next     = plane_reg;
        slice_next     = slice_reg;
        front_next     = front_reg;
        bright_next    = bright_reg;
        oe_max_next    = oe_max_reg;
        clear_next     = clear_reg;
        clr_addr_next  = clr_addr_reg;
        s1_valid_next  = cmd_fire ? is_tick : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;

        if (clear_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clear_next = 1'b0;
            end
        end

        if (cfg_we)
        begin
            unique case (paddr[2])
                hub75bs_pkg::REG_BRIGHTNESS:
                begin
                    bright_next = (pwdata[6:0] > hub75bs_pkg::BRIGHT_MAX)
                                  ? hub75bs_pkg::BRIGHT_MAX : pwdata[6:0];
                end
                hub75bs_pkg::REG_OE_MAX: oe_max_next = pwdata[7:0];
                default: ;
            endcase
        end

        if (cmd_fire && cmd.action == hub75bs_pkg::ACT_SWAP)
        begin
            front_next = ~front_reg;
        end

        if (cmd_fire && is_tick)
        begin
            unique case (state_reg)
                ST_BLANK:
                begin
                    state_next = ST_SHIFT;
                    col_next   = '0;
                    pidx_next  = '0;
                end
                ST_SHIFT:
                begin
                    if (col_reg == COL_W'(PANEL_W - 1))
                    begin
                        col_next = '0;
                        if (pidx_reg == PIDX_W'(SHIFT_PANELS - 1))
                        begin
                            state_next = ST_LATCH;
                        end
                        else
                        begin
                            pidx_next = pidx_reg + PIDX_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
                ST_LATCH:
                begin
                    slice_next = '0;
                    state_next = ST_SHOW;
                end
                ST_SHOW:
                begin
                    if (slice_inc >= slice_limit)
                    begin
                        slice_next = '0;
                        state_next = ST_BLANK;
                        if (row_reg == RW'(ADDR_ROWS - 1))
                        begin
                            row_next = '0;
                            if (plane_reg == PL_W'(PLANES - 1))
                            begin
                                plane_next = '0;
                            end
                            else
                            begin
                                plane_next = plane_reg + PL_W'(1);
                            end
                        end
                        else
                        begin
                            row_next = row_reg + RW'(1);
                        end
                    end
                    else
                    begin
                        slice_next = slice_inc;
                    end
                end
                default: state_next = ST_BLANK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BLANK;
            col_reg       <= '0;
            pidx_reg      <= '0;
            row_reg       <= '0;
            plane_reg     <= '0;
            slice_reg     <= '0;
            front_reg     <= 1'b0;
            bright_reg    <= hub75bs_pkg::BRIGHT_RESET;
            oe_max_reg    <= hub75bs_pkg::OE_MAX_RESET;
            clear_reg     <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            pidx_reg      <= pidx_next;
            row_reg       <= row_next;
            plane_reg     <= plane_next;
            slice_reg     <= slice_next;
            front_reg     <= front_next;
            bright_reg    <= bright_next;
            oe_max_reg    <= oe_max_next;
            clear_reg     <= clear_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The read stage feeds the output register that drives the pins beat.
    assign duty_full  = MUL_W'(product_reg) * MUL_W'(hub75bs_pkg::DIV100_MUL);
    assign upper_bits = rd_upper_reg[3*int'(s1_plane_reg) +: 3];
    assign lower_bits = rd_lower_reg[3*int'(s1_plane_reg) +: 3];

    always_ff @(posedge clk)
    begin
        product_reg <= PROD_W'(bright_reg * oe_max_reg);
        if (cmd_fire && is_tick)
        begin
            s1_shift_reg <= state_reg == ST_SHIFT;
            s1_latch_reg <= state_reg == ST_LATCH;
            s1_show_reg  <= state_reg == ST_SHOW;
            s1_row_reg   <= 3'(row_reg);
            s1_plane_reg <= plane_reg;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_reg.upper_red   <= s1_shift_reg && upper_bits[0];
            out_reg.upper_green <= s1_shift_reg && upper_bits[1];
            out_reg.upper_blue  <= s1_shift_reg && upper_bits[2];
            out_reg.lower_red   <= s1_shift_reg && lower_bits[0];
            out_reg.lower_green <= s1_shift_reg && lower_bits[1];
            out_reg.lower_blue  <= s1_shift_reg && lower_bits[2];
            out_reg.row_address <= s1_row_reg;
            out_reg.shift_clock <= s1_shift_reg;
            out_reg.latch_pulse <= s1_latch_reg;
            out_reg.oe_duty     <= s1_show_reg
                                   ? duty_full[hub75bs_pkg::DIV100_SHIFT +: 8] : 8'd0;
        end
    end

    assign pins_valid = out_valid_reg;
    assign pins       = out_reg;

`ifndef SYNTHESIS
    a_no_cmd_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clear_reg |-> !cmd_ready
    ) else $error("command taken during frame store clear");

    a_read_held_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> ($stable(rd_upper_reg) && $stable(rd_lower_reg))
    ) else $error("frame store read data lost while stalled");

    a_pin_step_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        pins_valid |-> ($countones({pins.shift_clock, pins.latch_pulse,
                                    pins.oe_duty != 8'd0}) <= 1)
    ) else $error("shift, latch and show overlap in one beat");

    a_write_not_during_read: assert property (
        @(posedge clk) disable iff (!rst_n) rd_en |-> !mem_we
    ) else $error("frame store read and write in the same cycle");
`endif

endmodule

`default_nettype wire

### bench/tb_hub75_bitplane_scan_driver_core.sv
`timescale 1ns / 1ps

module tb_hub75_bitplane_scan_driver_core;

    localparam int PANEL_W       = hub75bs_pkg::PANEL_W_DEF;
    localparam int PANEL_H       = hub75bs_pkg::PANEL_H_DEF;
    localparam int PANELS_ACROSS = hub75bs_pkg::PANELS_ACROSS_DEF;
    localparam int PANELS_DOWN   = hub75bs_pkg::PANELS_DOWN_DEF;
    localparam int PLANES        = hub75bs_pkg::PLANES_DEF;
    localparam int SLICE_TICKS   = hub75bs_pkg::SLICE_TICKS_DEF;

    localparam int PHYS_W     = PANEL_W * PANELS_ACROSS * PANELS_DOWN;
    localparam int VIRT_W     = PANEL_W * PANELS_ACROSS;
    localparam int VIRT_H     = PANEL_H * PANELS_DOWN;
    localparam int ADDR_ROWS  = PANEL_H / 4;
    localparam int SHIFT_COLS = PHYS_W * 2;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 1000000;

    class scan_tracker;
        logic [8:0] frame [2][PANEL_H][PHYS_W];
        bit         front;
        int         plane;
        int         row;
        int         phase;
        int         slice;
        logic [6:0] bright;
        logic [7:0] oe_max;
        hub75bs_pkg::pins_t expected_pins[$];
        int         failures;
        int         reported;
        int         beats;

        function new();
            foreach (frame[b, y, x])
            begin
                frame[b][y][x] = '0;
            end
            front    = 1'b0;
            plane    = 0;
            row      = 0;
            phase    = 0;
            slice    = 0;
            bright   = 7'd100;
            oe_max   = 8'd63;
            failures = 0;
            reported = 0;
            beats    = 0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == hub75bs_pkg::REG_BRIGHTNESS)
            begin
                bright = (value[6:0] > 7'd100) ? 7'd100 : value[6:0];
            end
            else
            begin
                oe_max = value[7:0];
            end
        endfunction

        function logic [2:0] gamma_code(logic [7:0] lvl);
            logic [2:0] n;
            n = (lvl >= 8'd48) + (lvl >= 8'd80) + (lvl >= 8'd104) + (lvl >= 8'd120)
              + (lvl >= 8'd132) + (lvl >= 8'd140) + (lvl >= 8'd148);
            return n;
        endfunction

        function void store_pixel(hub75bs_pkg::cmd_t c);
            int         px;
            int         py;
            logic [2:0] r;
            logic [2:0] g;
            logic [2:0] b;
            logic [8:0] word;
            if (c.pixel_x >= VIRT_W || c.pixel_y >= VIRT_H)
            begin
                return;
            end
            px = ((c.pixel_y / PANEL_H) * PANELS_ACROSS + c.pixel_x / PANEL_W) * PANEL_W
               + c.pixel_x % PANEL_W;
            py = c.pixel_y % PANEL_H;
            r = gamma_code(c.red_level);
            g = gamma_code(c.green_level);
            b = gamma_code(c.blue_level);
            word = '0;
            for (int p = 0; p < PLANES; p++)
            begin
                word[3*p]     = r[p];
                word[3*p + 1] = g[p];
                word[3*p + 2] = b[p];
            end
            frame[front ^ 1'b1][py][px] = word;
        endfunction

        function logic [2:0] plane_bits(int y, int x);
            logic [8:0] w;
            if (x >= PHYS_W || y >= PANEL_H)
            begin
                return 3'd0;
            end
            w = frame[front][y][x];
            return 3'(w >> (3 * plane));
        endfunction

        function hub75bs_pkg::pins_t next_pin_step();
            hub75bs_pkg::pins_t o;
            int         col;
            int         pidx;
            int         fx;
            int         y1;
            int         y2;
            logic [2:0] up;
            logic [2:0] lo;
            o = '0;
            o.row_address = 3'(row);
            if (phase == 0)
            begin
                phase = 1;
            end
            else if (phase <= SHIFT_COLS)
            begin
                col  = phase - 1;
                pidx = col / PANEL_W;
                fx   = (pidx / 2) * PANEL_W + col % PANEL_W;
                y1   = (pidx % 2 == 1) ? row : row + ADDR_ROWS;
                y2   = y1 + 2 * ADDR_ROWS;
                up   = plane_bits(y1, fx);
                lo   = plane_bits(y2, fx);
                o.upper_red   = up[0];
                o.upper_green = up[1];
                o.upper_blue  = up[2];
                o.lower_red   = lo[0];
                o.lower_green = lo[1];
                o.lower_blue  = lo[2];
                o.shift_clock = 1'b1;
                phase++;
            end
            else if (phase == SHIFT_COLS + 1)
            begin
                o.latch_pulse = 1'b1;
                slice = 0;
                phase++;
            end
            else
            begin
                o.oe_duty = 8'((int'(bright) * int'(oe_max)) / 100);
                slice++;
                if (slice >= (1 << plane) * SLICE_TICKS)
                begin
                    slice = 0;
                    phase = 0;
                    row++;
                    if (row >= ADDR_ROWS)
                    begin
                        row = 0;
                        plane = (plane + 1 >= PLANES) ? 0 : plane + 1;
                    end
                end
            end
            return o;
        endfunction

        function void take_command(hub75bs_pkg::cmd_t c);
            case (c.action)
                hub75bs_pkg::ACT_WRITE: store_pixel(c);
                hub75bs_pkg::ACT_SWAP:  front = front ^ 1'b1;
                hub75bs_pkg::ACT_TICK:  expected_pins.push_back(next_pin_step());
                default:   ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
            begin
                failures++;
                if (reported < 10)
                begin
                    $display("pins beat %0d: %s expected %0d, got %0d", beats, name, want, got);
                end
                reported++;
            end
        endfunction

        function void check_pins(hub75bs_pkg::pins_t got);
            hub75bs_pkg::pins_t want;
            if (expected_pins.size() == 0)
            begin
                failures++;
                if (reported < 10)
                begin
                    $display("pins beat %0d arrived with nothing expected: %p", beats, got);
                end
                reported++;
            end
            else
            begin
                want = expected_pins.pop_front();
                compare_field("upper_red", got.upper_red, want.upper_red);
                compare_field("upper_green", got.upper_green, want.upper_green);
                compare_field("upper_blue", got.upper_blue, want.upper_blue);
                compare_field("lower_red", got.lower_red, want.lower_red);
                compare_field("lower_green", got.lower_green, want.lower_green);
                compare_field("lower_blue", got.lower_blue, want.lower_blue);
                compare_field("row_address", got.row_address, want.row_address);
                compare_field("shift_clock", got.shift_clock, want.shift_clock);
                compare_field("latch_pulse", got.latch_pulse, want.latch_pulse);
                compare_field("oe_duty", got.oe_duty, want.oe_duty);
            end
            beats++;
        endfunction

        function void count_missing();
            if (expected_pins.size() != 0)
            begin
                failures += expected_pins.size();
                if (reported < 10)
                begin
                    $display("%0d pins beats expected but never delivered",
                             expected_pins.size());
                end
                reported++;
            end
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [hub75bs_pkg::APB_ADDR_W-1:0] paddr;
    logic [hub75bs_pkg::APB_DATA_W-1:0] pwdata;
    logic [hub75bs_pkg::APB_DATA_W-1:0] prdata;
    logic                               pready;
    logic                               cmd_valid;
    logic                               cmd_ready;
    hub75bs_pkg::cmd_t                  cmd;
    logic                               pins_valid;
    logic                               pins_ready = 1'b0;
    hub75bs_pkg::pins_t                 pins;

    scan_tracker tracker = new();
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int          hold_req = 0;
    int          cycle_count = 0;

    hub75_bitplane_scan_driver_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .pins_valid (pins_valid),
        .pins_ready (pins_ready),
        .pins       (pins)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_hub75_bitplane_scan_driver_core: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && pins_valid === 1'b1 && pins_ready === 1'b1)
        begin
            tracker.check_pins(pins);
        end
    end

    always
    begin : pins_sink
        int n;
        @(negedge clk);
        if (hold_req > 0)
        begin
            n = hold_req;
            hold_req = 0;
            pins_ready <= 1'b0;
            repeat (n) @(negedge clk);
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            pins_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        pins_ready <= 1'b1;
    end

    function automatic hub75bs_pkg::cmd_t make_cmd(logic [1:0] a, int x, int y,
                                                   int r, int g, int b);
        hub75bs_pkg::cmd_t c;
        c.action      = a;
        c.pixel_x     = 7'(x);
        c.pixel_y     = 7'(y);
        c.red_level   = 8'(r);
        c.green_level = 8'(g);
        c.blue_level  = 8'(b);
        return c;
    endfunction

    function automatic hub75bs_pkg::cmd_t random_cmd();
        hub75bs_pkg::cmd_t c;
        int                pick;
        c = make_cmd(hub75bs_pkg::ACT_TICK, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 76)
        begin
            c.action = hub75bs_pkg::ACT_TICK;
        end
        else if (pick < 96)
        begin
            c.action = hub75bs_pkg::ACT_WRITE;
            if ($urandom_range(0, 6) != 0)
            begin
                c.pixel_x = 7'($urandom_range(0, VIRT_W - 1));
                c.pixel_y = 7'($urandom_range(0, VIRT_H - 1));
            end
        end
        else if (pick < 99)
        begin
            c.action = hub75bs_pkg::ACT_SWAP;
        end
        else
        begin
            c.action = ACT_UNUSED;
        end
        return c;
    endfunction

    task automatic send_cmd(input hub75bs_pkg::cmd_t c, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_ready !== 1'b1)
        begin
            @(posedge clk);
        end
        tracker.take_command(c);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
        begin
            @(posedge clk);
        end
        tracker.set_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (tracker.expected_pins.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int ph);
        case (ph)
            0:
            begin
                apb_write(hub75bs_pkg::REG_BRIGHTNESS, 32'd0);
                apb_write(hub75bs_pkg::REG_OE_MAX, 32'd255);
            end
            1: apb_write(hub75bs_pkg::REG_BRIGHTNESS, 32'd127);
            2: apb_write(hub75bs_pkg::REG_OE_MAX, 32'd0);
            3:
            begin
                apb_write(hub75bs_pkg::REG_BRIGHTNESS, 32'd100);
                apb_write(hub75bs_pkg::REG_OE_MAX, 32'd1);
            end
            4:
            begin
                apb_write(hub75bs_pkg::REG_BRIGHTNESS, 32'd101);
                apb_write(hub75bs_pkg::REG_OE_MAX, 32'd200);
            end
            5:
            begin
                apb_write(hub75bs_pkg::REG_BRIGHTNESS, 32'd33);
                apb_write(hub75bs_pkg::REG_OE_MAX, 32'd77);
            end
            default:
            begin
                apb_write(hub75bs_pkg::REG_BRIGHTNESS, 32'd100);
                apb_write(hub75bs_pkg::REG_OE_MAX, 32'd63);
            end
        endcase
    endtask

    initial
    begin : stimulus
        int gap;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        cmd_valid = 1'b0;
        cmd       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_cmd(make_cmd(hub75bs_pkg::ACT_WRITE, 0, 8, 255, 255, 255), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_WRITE, 0, 24, 48, 47, 80), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_WRITE, 63, 31, 0, 255, 148), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_WRITE, 64, 0, 255, 255, 255), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_WRITE, 0, 32, 255, 255, 255), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_WRITE, 127, 127, 255, 255, 255), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_WRITE, 32, 0, 147, 104, 120), 0);
        send_cmd(make_cmd(ACT_UNUSED, 127, 127, 255, 255, 255), 0);
        send_cmd(make_cmd(ACT_UNUSED, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_TICK, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_TICK, 127, 127, 255, 255, 255), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_SWAP, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_WRITE, 1, 8, 120, 132, 140), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_TICK, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_SWAP, 127, 127, 255, 255, 255), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_TICK, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_SWAP, 0, 0, 0, 0, 0), 0);
        send_cmd(make_cmd(hub75bs_pkg::ACT_WRITE, 2, 8, 103, 119, 139), 0);
        for (int k = 0; k < 5; k++)
        begin
            send_cmd(make_cmd(hub75bs_pkg::ACT_TICK, 0, 0, 0, 0, 0), 0);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            configure(ph);
            gaps_on   = (ph < PHASES - 1);
            stalls_on = (ph < PHASES - 1);
            if (ph == 2)
            begin
                hold_req = HOLD_CYCLES;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                gap = (gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
                send_cmd(random_cmd(), gap);
            end
        end

        settle();
        tracker.count_missing();
        if (tracker.failures == 0)
        begin
            $display("tb_hub75_bitplane_scan_driver_core: done, clean");
        end
        else
        begin
            $display("tb_hub75_bitplane_scan_driver_core: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
design/hub75bs_pkg.sv
design/hub75_bitplane_scan_driver_core.sv
bench/tb_hub75_bitplane_scan_driver_core.sv
